>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the meeting-room block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/ivmo_pkg.sv
// Types and constants of the meeting-room overlap block.
`timescale 1ns / 1ps
package ivmo_pkg;

	localparam int unsigned FIELD_BITS = 16;
	localparam int unsigned ROOMS_BITS = 7;
	localparam int unsigned ROOMS_MAX  = 127;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PREP,
		ST_SCAN,
		ST_RED0,
		ST_REDUCE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_en;
		logic scan_start;
		logic scan_step;
		logic red_start;
		logic red_step;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/ivmo_channels.sv
// Request and result channel interfaces of the meeting-room overlap block.
`timescale 1ns / 1ps
interface ivmo_in_if;
	logic                            valid;
	logic                            ready;
	logic [ivmo_pkg::FIELD_BITS-1:0] meeting_start;
	logic [ivmo_pkg::FIELD_BITS-1:0] meeting_end;
	logic                            carries_meeting;
	logic                            last_meeting;

	modport source (output valid, meeting_start, meeting_end, carries_meeting,
		last_meeting, input ready);
	modport sink (input valid, meeting_start, meeting_end, carries_meeting,
		last_meeting, output ready);
endinterface

interface ivmo_out_if;
	logic                            valid;
	logic                            ready;
	logic [ivmo_pkg::ROOMS_BITS-1:0] rooms_needed;
	logic                            capacity_overflow;

	modport source (output valid, rooms_needed, capacity_overflow, input ready);
	modport sink (input valid, rooms_needed, capacity_overflow, output ready);
endinterface

>>> hw/rtl/ivmo_cell.sv
// One cell of the chain: holds one interval, counts overlapping probes, folds the peak.
`timescale 1ns / 1ps
module ivmo_cell #(
	parameter int unsigned TIME_BITS = 16,
	parameter int unsigned CW        = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ivmo_pkg::cell_ctrl_t ctrl,
	input  logic                 valid,
	input  logic [TIME_BITS-1:0] ld_start,
	input  logic [TIME_BITS-1:0] ld_end,
	output logic [TIME_BITS-1:0] held_start,
	output logic [TIME_BITS-1:0] held_end,
	input  logic [TIME_BITS-1:0] probe_start_prev,
	input  logic [TIME_BITS-1:0] probe_end_prev,
	input  logic                 probe_valid_prev,
	output logic [TIME_BITS-1:0] probe_start,
	output logic [TIME_BITS-1:0] probe_end,
	output logic                 probe_valid,
	input  logic [CW-1:0]        peak_prev,
	output logic [CW-1:0]        peak
);

	logic [TIME_BITS-1:0] start_q, end_q, pr_start_q, pr_end_q;
	logic                 pr_valid_q;
	logic [CW-1:0]        cnt_q, red_q;
	logic                 key_le, hit;

	// A probe counts when it sorts at or before this interval and is still
	// active at this interval's start.
	assign key_le = (probe_start_prev < start_q) ||
		((probe_start_prev == start_q) && (probe_end_prev <= end_q));
	assign hit = probe_valid_prev && key_le && (probe_end_prev > start_q);

	always_ff @(posedge clk) begin
		if (ctrl.load_en) begin
			start_q <= ld_start;
			end_q   <= ld_end;
		end
		if (ctrl.scan_start) begin
			pr_start_q <= start_q;
			pr_end_q   <= end_q;
		end else if (ctrl.scan_step) begin
			pr_start_q <= probe_start_prev;
			pr_end_q   <= probe_end_prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_valid_q <= 1'b0;
			cnt_q      <= '0;
			red_q      <= '0;
		end else begin
			if (ctrl.scan_start) begin
				pr_valid_q <= valid;
				cnt_q      <= '0;
			end else if (ctrl.scan_step) begin
				pr_valid_q <= probe_valid_prev;
				if (hit) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (ctrl.red_start) begin
				red_q <= valid ? cnt_q + CW'(1) : '0;
			end else if (ctrl.red_step) begin
				red_q <= (peak_prev > red_q) ? peak_prev : red_q;
			end
		end
	end

	assign held_start  = start_q;
	assign held_end    = end_q;
	assign probe_start = pr_start_q;
	assign probe_end   = pr_end_q;
	assign probe_valid = pr_valid_q;
	assign peak        = red_q;

endmodule

>>> hw/rtl/interval_max_overlap_rooms_core.sv
// Top level of the meeting-room overlap block: load control, cell chain and result register.
//
// Usage: intervals arrive on meeting_in, one request per cycle while ready is high.
// A request with carries_meeting set is shifted into the cell chain; once
// MAX_MEETINGS intervals are held, further ones are dropped and the set is
// marked as overflowed. A request with last_meeting set closes the set.
// After the closing request, ready stays low through a setup step, a scan in which
// every interval circulates once around the ring of cells, a step that seeds the
// peak values and a reduction in which the peak ripples down the chain, then a
// step that writes the result register once it is free. Requests are taken one
// per cycle while loading; a new set is not taken until the previous one has
// written its result. rooms_out holds the result until the receiver takes it; a
// new set loads meanwhile, and a second result waits in the last state until the
// register frees up. Reset empties the set and the result register; held
// interval data is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module interval_max_overlap_rooms_core #(
	parameter int unsigned MAX_MEETINGS = 64,
	parameter int unsigned TIME_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	ivmo_in_if.sink           meeting_in,
	ivmo_out_if.source        rooms_out
);

	localparam int unsigned CNT_W = $clog2(MAX_MEETINGS + 1);
	localparam int unsigned SW    = $clog2(MAX_MEETINGS);
	localparam int unsigned FB    = ivmo_pkg::FIELD_BITS;
	localparam int unsigned RB    = ivmo_pkg::ROOMS_BITS;

	ivmo_pkg::state_t     state_q, state_d;
	ivmo_pkg::cell_ctrl_t ctrl;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic [SW-1:0]    step_q;
	logic             out_valid_q, ovf_out_q;
	logic [RB-1:0]    rooms_q, rooms_w;
	logic             in_ready, accept, out_free, step_end, full;
	logic [TIME_BITS-1:0] new_start, new_end;

	logic [TIME_BITS-1:0] held_start [MAX_MEETINGS];
	logic [TIME_BITS-1:0] held_end   [MAX_MEETINGS];
	logic [TIME_BITS-1:0] pr_start   [MAX_MEETINGS];
	logic [TIME_BITS-1:0] pr_end     [MAX_MEETINGS];
	logic                 pr_valid   [MAX_MEETINGS];
	logic [CNT_W-1:0]     peak       [MAX_MEETINGS];

	generate
		if (TIME_BITS <= FB) begin : g_narrow
			assign new_start = meeting_in.meeting_start[TIME_BITS-1:0];
			assign new_end   = meeting_in.meeting_end[TIME_BITS-1:0];
		end else begin : g_wide
			assign new_start = {{(TIME_BITS - FB){1'b0}}, meeting_in.meeting_start};
			assign new_end   = {{(TIME_BITS - FB){1'b0}}, meeting_in.meeting_end};
		end
	endgenerate

	assign accept   = meeting_in.valid && in_ready;
	assign full     = (count_q == CNT_W'(MAX_MEETINGS));
	assign out_free = !out_valid_q || rooms_out.ready;
	assign step_end = (step_q == SW'(MAX_MEETINGS - 2));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ivmo_pkg::ST_LOAD: begin
				if (accept && meeting_in.last_meeting) state_d = ivmo_pkg::ST_PREP;
			end
			ivmo_pkg::ST_PREP:   state_d = ivmo_pkg::ST_SCAN;
			ivmo_pkg::ST_SCAN: begin
				if (step_end) state_d = ivmo_pkg::ST_RED0;
			end
			ivmo_pkg::ST_RED0:   state_d = ivmo_pkg::ST_REDUCE;
			ivmo_pkg::ST_REDUCE: begin
				if (step_end) state_d = ivmo_pkg::ST_DONE;
			end
			ivmo_pkg::ST_DONE: begin
				if (out_free) state_d = ivmo_pkg::ST_LOAD;
			end
			default:             state_d = ivmo_pkg::ST_LOAD;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_ready = 1'b0;
		ctrl     = '0;
		case (state_q)
			ivmo_pkg::ST_LOAD: begin
				in_ready     = 1'b1;
				ctrl.load_en = meeting_in.valid && meeting_in.carries_meeting && !full;
			end
			ivmo_pkg::ST_PREP:   ctrl.scan_start = 1'b1;
			ivmo_pkg::ST_SCAN:   ctrl.scan_step  = 1'b1;
			ivmo_pkg::ST_RED0:   ctrl.red_start  = 1'b1;
			ivmo_pkg::ST_REDUCE: ctrl.red_step   = 1'b1;
			ivmo_pkg::ST_DONE:   ;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ivmo_pkg::ST_LOAD;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (accept && meeting_in.carries_meeting && full) begin
				ovf_q <= 1'b1;
			end
			if (ctrl.scan_start || ctrl.red_start) begin
				step_q <= '0;
			end else if (ctrl.scan_step || ctrl.red_step) begin
				step_q <= step_q + SW'(1);
			end
			if (state_q == ivmo_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				ovf_q       <= 1'b0;
			end else if (rooms_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ivmo_pkg::ST_DONE && out_free) begin
			rooms_q   <= rooms_w;
			ovf_out_q <= ovf_q;
		end
	end

	generate
		if (CNT_W > RB) begin : g_sat
			assign rooms_w = (peak[MAX_MEETINGS-1] > CNT_W'(ivmo_pkg::ROOMS_MAX)) ?
				RB'(ivmo_pkg::ROOMS_MAX) : peak[MAX_MEETINGS-1][RB-1:0];
		end else begin : g_ext
			assign rooms_w = RB'(peak[MAX_MEETINGS-1]);
		end
	endgenerate

	genvar k;
	generate
		for (k = 0; k < MAX_MEETINGS; k++) begin : g_cell
			localparam int unsigned PREV = (k + MAX_MEETINGS - 1) % MAX_MEETINGS;
			logic [TIME_BITS-1:0] ld_s, ld_e;
			logic [CNT_W-1:0]     pk_prev;
			logic                 cell_valid;

			assign cell_valid = (count_q > CNT_W'(k));
			if (k == 0) begin : g_head
				assign ld_s    = new_start;
				assign ld_e    = new_end;
				assign pk_prev = '0;
			end else begin : g_body
				assign ld_s    = held_start[k-1];
				assign ld_e    = held_end[k-1];
				assign pk_prev = peak[k-1];
			end

			ivmo_cell #(
				.TIME_BITS (TIME_BITS),
				.CW        (CNT_W)
			) u_cell (
				.clk              (clk),
				.arst_n           (arst_n),
				.ctrl             (ctrl),
				.valid            (cell_valid),
				.ld_start         (ld_s),
				.ld_end           (ld_e),
				.held_start       (held_start[k]),
				.held_end         (held_end[k]),
				.probe_start_prev (pr_start[PREV]),
				.probe_end_prev   (pr_end[PREV]),
				.probe_valid_prev (pr_valid[PREV]),
				.probe_start      (pr_start[k]),
				.probe_end        (pr_end[k]),
				.probe_valid      (pr_valid[k]),
				.peak_prev        (pk_prev),
				.peak             (peak[k])
			);
		end
	endgenerate

	assign meeting_in.ready            = in_ready;
	assign rooms_out.valid             = out_valid_q;
	assign rooms_out.rooms_needed      = rooms_q;
	assign rooms_out.capacity_overflow = ovf_out_q;

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(MAX_MEETINGS))
	`ASSERT_AT(a_ovf_only_full, clk, arst_n, ovf_q |-> full)
	`ASSERT_AT(a_step_cleared, clk, arst_n, (state_q == ivmo_pkg::ST_PREP) |=> (step_q == '0))
	`ASSERT_AT(a_rooms_le_count, clk, arst_n,
		(state_q == ivmo_pkg::ST_DONE && out_free) |=> (CNT_W'(rooms_q) <= $past(count_q)))

endmodule

>>> test/tb.sv
// Testbench of the meeting-room overlap block: directed sets, random sets, predicted peaks.
`timescale 1ns / 1ps
module tb;

	localparam int unsigned MEETING_SLOTS = 64;
	localparam int unsigned SWEEP_CYCLES  = 2 * MEETING_SLOTS + 1;
	localparam int unsigned RANDOM_ITEMS  = 2000;
	localparam int unsigned LONG_HOLD     = 800;
	localparam int unsigned STALL_LIMIT   = 5000;
	localparam int unsigned DIR_ROWS      = 23;

	typedef logic [ivmo_pkg::FIELD_BITS-1:0] stamp_t;
	typedef logic [ivmo_pkg::ROOMS_BITS-1:0] rooms_t;

	typedef struct packed {
		stamp_t start_t;
		stamp_t end_t;
	} meeting_t;

	typedef struct packed {
		rooms_t rooms;
		logic   overflow;
	} room_count_t;

	typedef struct packed {
		stamp_t start_t;
		stamp_t end_t;
		logic   carries;
		logic   last_flag;
		logic   typed;
		rooms_t rooms;
		logic   overflow;
	} dir_row_t;

	typedef enum {SPREAD_WIDE, SPREAD_CLUSTER, SPREAD_TIGHT} spread_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ivmo_in_if  req_if();
	ivmo_out_if res_if();

	interval_max_overlap_rooms_core #(
		.MAX_MEETINGS(MEETING_SLOTS),
		.TIME_BITS   (ivmo_pkg::FIELD_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.meeting_in(req_if),
		.rooms_out (res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the open set kept sorted by start, then by end.
	meeting_t    open_set[$];
	logic        open_dropped = 1'b0;
	room_count_t awaited_counts[$];

	// Typed expectation that travels with the request currently on the bus.
	logic        row_typed = 1'b0;
	room_count_t row_count = '0;

	bit no_idle       = 1'b0;
	bit long_hold_req = 1'b0;

	int unsigned n_requests, n_sets, n_over_sets, n_empty_sets, top_peak, n_errors;

	function automatic void file_meeting(meeting_t m);
		int unsigned slot;
		if (open_set.size() >= MEETING_SLOTS) begin
			open_dropped = 1'b1;
			return;
		end
		slot = open_set.size();
		while (slot > 0 && (open_set[slot-1].start_t > m.start_t ||
				(open_set[slot-1].start_t == m.start_t && open_set[slot-1].end_t > m.end_t)))
			slot--;
		open_set.insert(slot, m);
	endfunction

	// Sweep in start order; the sorted list of busy end times plays the part of the heap,
	// since only its smallest entry is ever released.
	function automatic int unsigned peak_rooms();
		stamp_t      busy_until[$];
		int unsigned peak;
		int unsigned slot;
		peak = 0;
		foreach (open_set[i]) begin
			while (busy_until.size() > 0 && open_set[i].start_t >= busy_until[0])
				void'(busy_until.pop_front());
			slot = busy_until.size();
			while (slot > 0 && busy_until[slot-1] > open_set[i].end_t)
				slot--;
			busy_until.insert(slot, open_set[i].end_t);
			if (busy_until.size() > peak)
				peak = busy_until.size();
		end
		return (peak > ivmo_pkg::ROOMS_MAX) ? ivmo_pkg::ROOMS_MAX : peak;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		n_errors++;
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin : request_monitor
		room_count_t due;
		if (arst_n && req_if.valid && req_if.ready) begin
			n_requests++;
			if (req_if.carries_meeting)
				file_meeting('{req_if.meeting_start, req_if.meeting_end});
			if (req_if.last_meeting) begin
				due.rooms    = rooms_t'(peak_rooms());
				due.overflow = open_dropped;
				if (row_typed)
					due = row_count;
				awaited_counts.push_back(due);
				n_sets++;
				if (open_dropped)
					n_over_sets++;
				if (open_set.size() == 0)
					n_empty_sets++;
				if (due.rooms > top_peak)
					top_peak = due.rooms;
				open_set.delete();
				open_dropped = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		room_count_t due;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (awaited_counts.size() == 0) begin
				report_mismatch("result with nothing outstanding, rooms_needed",
					res_if.rooms_needed, 0);
			end else begin
				due = awaited_counts.pop_front();
				if (res_if.rooms_needed !== due.rooms)
					report_mismatch("rooms_needed", res_if.rooms_needed, due.rooms);
				if (res_if.capacity_overflow !== due.overflow)
					report_mismatch("capacity_overflow", res_if.capacity_overflow, due.overflow);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : result_sink
		int unsigned pick;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pick = $urandom_range(0, 19);
			if (long_hold_req) begin
				// Long hold-off: the block fills up and has to stall its request side.
				res_if.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				long_hold_req = 1'b0;
			end else if (!no_idle && pick == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(0, 15)) @(negedge clk);
			end else if (pick == 1) begin
				res_if.ready <= 1'b1;
				repeat ($urandom_range(31, 127)) @(negedge clk);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	task automatic offer_request(input stamp_t s, input stamp_t e,
			input logic carries, input logic last_flag, input logic typed,
			input rooms_t rooms, input logic overflow);
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 16)) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
			end
		end
		@(negedge clk);
		req_if.valid           <= 1'b1;
		req_if.meeting_start   <= s;
		req_if.meeting_end     <= e;
		req_if.carries_meeting <= carries;
		req_if.last_meeting    <= last_flag;
		row_typed              <= typed;
		row_count              <= '{rooms, overflow};
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic await_results();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (awaited_counts.size() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		dir_row_t    rows [DIR_ROWS];
		int unsigned sent, set_no, set_size, pick;
		spread_t     spread;
		stamp_t      base, s, e;
		bit          split_close;

		req_if.valid           = 1'b0;
		req_if.meeting_start   = '0;
		req_if.meeting_end     = '0;
		req_if.carries_meeting = 1'b0;
		req_if.last_meeting    = 1'b0;

		// start, end, carries, last, typed, rooms, overflow
		rows = '{
			'{16'd0,     16'd0,     1'b0, 1'b1, 1'b1, 7'd0, 1'b0}, // empty set after reset
			'{16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 7'd0, 1'b0}, // neither flag: ignored
			'{16'd0,     16'd65535, 1'b1, 1'b1, 1'b1, 7'd1, 1'b0}, // widest single interval
			'{16'd65535, 16'd65535, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
			'{16'd65535, 16'd0,     1'b1, 1'b1, 1'b0, 7'd0, 1'b0}, // top start, end wrapped
			'{16'd0,     16'd100,   1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
			'{16'd100,   16'd200,   1'b1, 1'b1, 1'b1, 7'd1, 1'b0}, // touching: room reused
			'{16'd5,     16'd10,    1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
			'{16'd5,     16'd10,    1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
			'{16'd5,     16'd10,    1'b1, 1'b1, 1'b1, 7'd3, 1'b0}, // three identical
			'{16'd50,    16'd10,    1'b1, 1'b0, 1'b0, 7'd0, 1'b0}, // end before start
			'{16'd20,    16'd30,    1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
			'{16'd40,    16'd45,    1'b1, 1'b1, 1'b0, 7'd0, 1'b0},
			'{16'd7,     16'd7,     1'b1, 1'b0, 1'b0, 7'd0, 1'b0}, // zero length
			'{16'd7,     16'd9,     1'b1, 1'b1, 1'b0, 7'd0, 1'b0},
			'{16'd1,     16'd1000,  1'b1, 1'b0, 1'b0, 7'd0, 1'b0}, // nested intervals
			'{16'd2,     16'd999,   1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
			'{16'd0,     16'd0,     1'b0, 1'b0, 1'b0, 7'd0, 1'b0}, // ignored inside a set
			'{16'd3,     16'd998,   1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
			'{16'd0,     16'd0,     1'b0, 1'b1, 1'b0, 7'd0, 1'b0}, // closed without interval
			'{16'hAAAA,  16'h5555,  1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
			'{16'h5555,  16'hAAAA,  1'b1, 1'b1, 1'b0, 7'd0, 1'b0},
			'{16'd65535, 16'd65535, 1'b0, 1'b1, 1'b1, 7'd0, 1'b0}  // empty set, junk fields
		};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i])
			offer_request(rows[i].start_t, rows[i].end_t, rows[i].carries, rows[i].last_flag,
				rows[i].typed, rows[i].rooms, rows[i].overflow);
		await_results();

		sent = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			set_no++;
			if (sent > RANDOM_ITEMS * 17 / 20)
				no_idle = 1'b1;
			if (set_no % 40 == 0)
				await_results();
			if (set_no == 25)
				long_hold_req = 1'b1;

			pick = $urandom_range(0, 99);
			if (set_no >= 25 && set_no < 31)
				set_size = $urandom_range(2, 4);
			else if (pick < 3)
				set_size = 0;
			else if (pick < 75)
				set_size = $urandom_range(1, 8);
			else if (pick < 92)
				set_size = $urandom_range(9, 40);
			else if (pick < 97)
				set_size = $urandom_range(41, 64);
			else
				set_size = $urandom_range(65, 72);

			spread = spread_t'($urandom_range(0, 2));
			base = stamp_t'($urandom);
			split_close = (set_size == 0) || ($urandom_range(0, 3) == 0);

			for (int k = 0; k < set_size; k++) begin
				if ($urandom_range(0, 19) == 0)
					offer_request(stamp_t'($urandom), stamp_t'($urandom), 1'b0, 1'b0, 1'b0,
						'0, 1'b0);
				case (spread)
					SPREAD_WIDE: begin
						s = stamp_t'($urandom);
						e = stamp_t'($urandom);
					end
					SPREAD_CLUSTER: begin
						s = stamp_t'(base + $urandom_range(0, 2000));
						e = stamp_t'(s + $urandom_range(0, 600));
					end
					default: begin
						s = stamp_t'(base + $urandom_range(0, 30));
						e = stamp_t'(s + $urandom_range(1, 40));
					end
				endcase
				if ($urandom_range(0, 9) == 0)
					e = stamp_t'(s - $urandom_range(0, 50));
				offer_request(s, e, 1'b1, !split_close && k == set_size - 1, 1'b0, '0, 1'b0);
				sent++;
			end
			if (split_close) begin
				offer_request(stamp_t'($urandom), stamp_t'($urandom), 1'b0, 1'b1, 1'b0,
					'0, 1'b0);
				sent++;
			end
		end

		await_results();
		repeat (SWEEP_CYCLES + 16) @(negedge clk);
		if (awaited_counts.size() != 0)
			report_mismatch("results still outstanding at the end", 0, awaited_counts.size());

		$display("Sent %0d requests forming %0d sets (%0d empty, %0d over capacity).",
			n_requests, n_sets, n_empty_sets, n_over_sets);
		$display("Largest room count seen was %0d; %0d mismatches found.", top_peak, n_errors);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
